// ===== sv/sha256_pkg.sv =====
// SHA-256 hasher package: payload structs, round constants, initial hash values.
// Used by sha256_round and sha256_byte_stream_hasher.
package sha256_pkg;

    localparam int WordW  = 32;
    localparam int Rounds = 64;

    typedef logic [WordW-1:0] t_word;

    localparam logic CmdAbsorb = 1'b0;
    localparam logic CmdFinish = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0] word_index;
        t_word      digest_word;
        logic       last;
    } t_out;

    typedef struct packed {
        t_word a, b, c, d, e, f, g, h;
    } t_vars;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19 };

    localparam t_word RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2 };

endpackage

// ===== sv/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher, top level: byte packing, padding, round sequencer, digest out.
// Depends on sha256_pkg and sha256_round.
// A data transaction (cmd 0) is absorbed in the idle state; the 64th byte of a block then
// runs the 64 rounds and a chaining add, since one shared round unit does one round a cycle.
// A finish transaction pads the remaining words of the block and runs one or two blocks (an
// extra block first zeroes its words and writes the length), then presents eight digest
// words, most significant first, one per transaction on the output; no input is taken
// until the last word has left.
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state      r_state;
    t_word       r_h [8];
    t_word       r_w [16];
    t_vars       r_v;
    logic [63:0] r_count;
    logic [5:0]  r_t;
    logic [3:0]  r_pw;
    logic        r_fin;
    logic        r_len_done;
    logic [2:0]  r_oi;

    t_vars v_next;
    t_word w_next;

    sha256_round u_round (
        .i_v(r_v), .i_w(r_w[0]), .i_t(r_t), .i_w1(r_w[1]), .i_w9(r_w[9]),
        .i_w14(r_w[14]), .o_v(v_next), .o_w_next(w_next)
    );

    logic [5:0] pos;
    logic [1:0] bsel;
    logic [3:0] widx;
    logic [63:0] bits;
    assign pos  = r_count[5:0];
    assign bsel = pos[1:0];
    assign widx = pos[5:2];
    assign bits = {r_count[60:0], 3'b000};

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = '{word_index: r_oi, digest_word: r_h[r_oi], last: (r_oi == 3'd7)};

    function automatic t_word put(input t_word w, input logic [1:0] b, input logic [7:0] d);
        t_word m;
        m = w;
        m[(3 - b) * 8 +: 8] = d;
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_fin   <= 1'b0;
            r_len_done <= 1'b0;
            r_oi    <= '0;
            r_t     <= '0;
            r_pw    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.cmd == CmdAbsorb) begin
                            r_w[widx] <= put(r_w[widx], bsel, i_data.data_byte);
                            r_count   <= r_count + 64'd1;
                            if (pos == 6'd63) begin
                                r_fin   <= 1'b0;
                                r_t     <= '0;
                                r_v     <= '{r_h[0], r_h[1], r_h[2], r_h[3],
                                             r_h[4], r_h[5], r_h[6], r_h[7]};
                                r_state <= S_ROUND;
                            end
                        end else begin
                            // 0x80 then zero the rest of this word
                            r_w[widx] <= put(r_w[widx], bsel, 8'h80)
                                         & ~(32'hffffffff >> ((bsel + 3'd1) * 8));
                            r_pw       <= widx + 4'd1;
                            r_fin      <= 1'b1;
                            r_len_done <= (widx < 4'd14);
                            r_state    <= (widx == 4'd15) ? S_ROUND : S_PAD;
                            r_t        <= '0;
                            r_v        <= '{r_h[0], r_h[1], r_h[2], r_h[3],
                                            r_h[4], r_h[5], r_h[6], r_h[7]};
                        end
                    end
                end
                S_PAD: begin
                    // zero remaining words; length goes in words 14, 15 of the last block
                    if (r_len_done && r_pw == 4'd14) r_w[r_pw] <= bits[63:32];
                    else if (r_len_done && r_pw == 4'd15) r_w[r_pw] <= bits[31:0];
                    else r_w[r_pw] <= '0;
                    r_pw <= r_pw + 4'd1;
                    if (r_pw == 4'd15) begin
                        r_t     <= '0;
                        r_v     <= '{r_h[0], r_h[1], r_h[2], r_h[3],
                                     r_h[4], r_h[5], r_h[6], r_h[7]};
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v <= v_next;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_next;
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_v.a; r_h[1] <= r_h[1] + r_v.b;
                    r_h[2] <= r_h[2] + r_v.c; r_h[3] <= r_h[3] + r_v.d;
                    r_h[4] <= r_h[4] + r_v.e; r_h[5] <= r_h[5] + r_v.f;
                    r_h[6] <= r_h[6] + r_v.g; r_h[7] <= r_h[7] + r_v.h;
                    if (!r_fin) r_state <= S_IDLE;
                    else if (r_len_done) begin
                        r_oi    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // extra block: zeros then length
                        r_len_done <= 1'b1;
                        r_pw       <= '0;
                        r_state    <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
                            r_count <= '0;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/sha256_round.sv =====
// SHA-256 round datapath: one compression round and one schedule word per call.
// Depends on sha256_pkg.
module sha256_round
    import sha256_pkg::*;
(
    input  t_vars      i_v,
    input  t_word      i_w,
    input  logic [5:0] i_t,
    input  t_word      i_w1,
    input  t_word      i_w9,
    input  t_word      i_w14,
    output t_vars      o_v,
    output t_word      o_w_next
);
    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    t_word s0, s1, ch, maj, t1, t2, ss0, ss1;

    always_comb begin
        s1  = rotr(i_v.e, 6) ^ rotr(i_v.e, 11) ^ rotr(i_v.e, 25);
        ch  = (i_v.e & i_v.f) ^ (~i_v.e & i_v.g);
        t1  = i_v.h + s1 + ch + RoundK[i_t] + i_w;
        s0  = rotr(i_v.a, 2) ^ rotr(i_v.a, 13) ^ rotr(i_v.a, 22);
        maj = (i_v.a & i_v.b) ^ (i_v.a & i_v.c) ^ (i_v.b & i_v.c);
        t2  = s0 + maj;
        o_v = '{a: t1 + t2, b: i_v.a, c: i_v.b, d: i_v.c,
                e: i_v.d + t1, f: i_v.e, g: i_v.f, h: i_v.g};
        // schedule: w[t+16] = w[t] + s0(w[t+1]) + w[t+9] + s1(w[t+14])
        ss0 = rotr(i_w1, 7) ^ rotr(i_w1, 18) ^ (i_w1 >> 3);
        ss1 = rotr(i_w14, 17) ^ rotr(i_w14, 19) ^ (i_w14 >> 10);
        o_w_next = i_w + ss0 + i_w9 + ss1;
    end
endmodule

// ===== verif/sha256_byte_stream_hasher_tb.sv =====
// Testbench for sha256_byte_stream_hasher: random byte messages with finish transactions,
// digest words checked against an in-bench SHA-256 predictor. Depends on sha256_pkg.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_tb;
    import sha256_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    sha256_byte_stream_hasher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    localparam logic [31:0] HashK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2 };
    localparam logic [31:0] HashIv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19 };

    // predictor state
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [63:0] n_bytes;

    t_in  pending_q [$];
    t_out digest_q [$];
    int   errors;
    int   cycles;
    int   src_idle_pct;
    int   dst_idle_pct;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, x15, x2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                x15 = w[(t - 15) & 15];
                x2 = w[(t - 2) & 15];
                s0 = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
                s1 = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
                w[t & 15] = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
            end
            s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + HashK[t] + w[t & 15];
            s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
    endtask

    task automatic place_byte(int pos, logic [7:0] b);
        int sh;
        sh = (3 - (pos & 3)) * 8;
        blk[pos >> 2] = (blk[pos >> 2] & ~(32'hff << sh)) | ({24'd0, b} << sh);
    endtask

    task automatic hash_predict(t_in it);
        int pos;
        logic [63:0] nbits;
        t_out r;
        pos = int'(n_bytes[5:0]);
        if (it.cmd == CmdAbsorb) begin
            place_byte(pos, it.data_byte);
            n_bytes = n_bytes + 1;
            if (pos == 63) compress();
        end else begin
            place_byte(pos, 8'h80);
            for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 16; i++) blk[i] = '0;
            end
            nbits = n_bytes << 3;
            blk[14] = nbits[63:32];
            blk[15] = nbits[31:0];
            compress();
            for (int i = 0; i < 8; i++) begin
                r.word_index = 3'(i);
                r.digest_word = hv[i];
                r.last = (i == 7);
                digest_q.push_back(r);
            end
            for (int i = 0; i < 8; i++) hv[i] = HashIv[i];
            n_bytes = '0;
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic add_msg(int len);
        t_in it;
        for (int i = 0; i < len; i++) begin
            it.cmd = CmdAbsorb;
            it.data_byte = 8'($urandom_range(0, 255));
            pending_q.push_back(it);
        end
        it.cmd = CmdFinish;
        it.data_byte = 8'($urandom_range(0, 255));
        pending_q.push_back(it);
    endtask

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) hash_predict(i_data);
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                i_valid <= 1'b1;
                i_data <= pending_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    report("unexpected word", {29'd0, o_data.word_index}, 32'd0);
                end else begin
                    want = digest_q.pop_front();
                    if (o_data.word_index != want.word_index)
                        report("word_index", {29'd0, o_data.word_index},
                               {29'd0, want.word_index});
                    if (o_data.digest_word != want.digest_word)
                        report("digest_word", o_data.digest_word, want.digest_word);
                    if (o_data.last != want.last)
                        report("last", {31'd0, o_data.last}, {31'd0, want.last});
                end
            end
            i_stall <= ($urandom_range(0, 99) < dst_idle_pct);
        end
        if (cycles > 400000) begin
            $display("sha256_byte_stream_hasher_tb failed");
            $finish;
        end
    end

    task automatic run_phase(int src_pct, int dst_pct, int n_items);
        int target;
        int len;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        target = pending_q.size() + n_items;
        while (pending_q.size() < target) begin
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 66);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(0, 40);
            endcase
            add_msg(len);
        end
        while (pending_q.size() > 0 || i_valid) @(posedge i_clk);
    endtask

    initial begin
        t_in it;
        errors = 0;
        cycles = 0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        for (int i = 0; i < 8; i++) hv[i] = HashIv[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        n_bytes = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty message, extreme bytes, padding boundary at 55/56 bytes, block boundary at 63/64
        add_msg(0);
        it.cmd = CmdAbsorb;
        it.data_byte = 8'h00;
        pending_q.push_back(it);
        it.data_byte = 8'hff;
        pending_q.push_back(it);
        it.cmd = CmdFinish;
        it.data_byte = 8'hff;
        pending_q.push_back(it);
        add_msg(0);
        add_msg(1);
        run_phase(0, 0, 0);
        add_msg(55);
        add_msg(56);
        add_msg(63);
        add_msg(64);
        run_phase(10, 54, 40);
        run_phase(54, 10, 40);
        run_phase(0, 0, 40);
        while (digest_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("sha256_byte_stream_hasher_tb passed");
        end else begin
            $display("sha256_byte_stream_hasher_tb failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/sha256_pkg.sv
sv/sha256_round.sv
sv/sha256_byte_stream_hasher.sv
verif/sha256_byte_stream_hasher_tb.sv
